### design/rmoc_pkg.sv
// shared types, constants and helpers for the region map overlap checker
package rmoc_pkg;

    // table depth and page size
    localparam int unsigned MAX_REGIONS = 16;
    localparam int unsigned PAGE_BYTES  = 4096;
    localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int unsigned IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int unsigned CNT_W       = $clog2(MAX_REGIONS + 1);

    // request kinds
    localparam logic [1:0] K_REGION = 2'd0;
    localparam logic [1:0] K_STACK  = 2'd1;
    localparam logic [1:0] K_HEAP   = 2'd2;
    localparam logic [1:0] K_BRK    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_MEETS   = 3'd3;
    localparam logic [2:0] ST_NO_HEAP = 3'd4;

    // request beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] length;
        logic [3:0]  access_rights;
    } t_req;

    // result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
    } t_rsp;

    // one region table entry
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] top;
        logic [3:0]  rights;
    } t_entry;

    // round a 32-bit byte count up to whole pages, carry kept in bit 32
    function automatic logic [32:0] round_up_page(input logic [31:0] v);
        logic [32:0] sum;
        sum = {1'b0, v} + 33'(PAGE_BYTES - 1);
        return sum & ~33'(PAGE_BYTES - 1);
    endfunction

endpackage

### design/rmoc_region_table.sv
// region table storage: one write port, one registered read port
module rmoc_region_table
    import rmoc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [MAX_REGIONS];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/rmoc_overlap_unit.sv
// shared overlap comparator: [b1, t1) against [b2, t2)
module rmoc_overlap_unit
    import rmoc_pkg::*;
(
    input  logic [31:0] i_b1,
    input  logic [31:0] i_t1,
    input  logic [31:0] i_b2,
    input  logic [31:0] i_t2,
    output logic        o_hit
);

    logic left_of;
    logic right_of;

    // clear only when wholly left or wholly right of the other range
    assign left_of  = (i_b1 < i_b2) && (i_t1 <= i_b2);
    assign right_of = (i_b1 >= i_t2) && (i_t1 >= i_t2);
    assign o_hit    = !(left_of || right_of);

endmodule

### design/region_map_overlap_checker.sv
// Region map overlap checker: a table of up to MAX_REGIONS page-granular address
// regions plus one stack and one heap, with define-region, define-stack, define-heap
// and heap-break requests, one result beat per request beat. One overlap comparator is
// stepped through the stack and then the table, one entry per cycle through the
// table's single registered read port, stopping at the first hit. A request that is
// rejected during setup goes straight to the finish state; a region, stack or break
// request that reaches the overlap walk passes through the stack compare and the table
// walk; a heap definition first walks the table for the highest region top. The input
// is ready only while no request is in progress; a finished result sits in an output
// register and the next request may be accepted while it waits to be taken.
module region_map_overlap_checker
    import rmoc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MAX  = 3'd2;
    localparam logic [2:0] S_HEAP = 3'd3;
    localparam logic [2:0] S_STK  = 3'd4;
    localparam logic [2:0] S_TBL  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       r_state, n_state;
    t_req             r_req, n_req;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_qb, n_qb;
    logic [31:0]      r_qt, n_qt;
    logic [31:0]      r_max, n_max;
    logic [31:0]      r_stack_base, n_stack_base;
    logic [31:0]      r_stack_top, n_stack_top;
    logic             r_stack_valid, n_stack_valid;
    logic [31:0]      r_heap_base, n_heap_base;
    logic             r_heap_valid, n_heap_valid;
    logic [2:0]       r_status, n_status;
    logic [31:0]      r_value, n_value;
    t_rsp             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             wr_en;
    t_entry           wr_data;
    t_entry           rd_data;
    logic [31:0]      ov_b2;
    logic [31:0]      ov_t2;
    logic             ov_hit;
    logic [31:0]      pg_base;
    logic [32:0]      size_rnd;
    logic [33:0]      reg_top;
    logic [32:0]      heap_rnd;

    // region table
    assign wr_data = '{base: r_qb, top: r_qt, rights: r_req.access_rights};

    rmoc_region_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (n_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // shared comparator: stack first, then table entries
    assign ov_b2 = (r_state == S_STK) ? r_stack_base : rd_data.base;
    assign ov_t2 = (r_state == S_STK) ? r_stack_top  : rd_data.top;

    rmoc_overlap_unit u_overlap (
        .i_b1  (r_qb),
        .i_t1  (r_qt),
        .i_b2  (ov_b2),
        .i_t2  (ov_t2),
        .o_hit (ov_hit)
    );

    // page arithmetic on the held request
    assign pg_base  = {r_req.addr[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    assign size_rnd = round_up_page(r_req.length);
    assign reg_top  = {2'b00, pg_base} + {1'b0, size_rnd};
    assign heap_rnd = round_up_page(r_max);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_idx         = r_idx;
        n_count       = r_count;
        n_qb          = r_qb;
        n_qt          = r_qt;
        n_max         = r_max;
        n_stack_base  = r_stack_base;
        n_stack_top   = r_stack_top;
        n_stack_valid = r_stack_valid;
        n_heap_base   = r_heap_base;
        n_heap_valid  = r_heap_valid;
        n_status      = r_status;
        n_value       = r_value;
        n_out         = r_out;
        n_out_valid   = r_out_valid;
        wr_en         = 1'b0;

        // result beat taken downstream
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_status = ST_OK;
                n_value  = '0;
                n_idx    = '0;
                unique case (r_req.kind)
                    K_REGION: begin
                        if (r_count >= CNT_W'(MAX_REGIONS)) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else if (|reg_top[33:32]) begin
                            n_status = ST_INVALID;
                            n_state  = S_FIN;
                        end else begin
                            n_qb    = pg_base;
                            n_qt    = reg_top[31:0];
                            n_state = S_STK;
                        end
                    end
                    K_STACK: begin
                        if ((|r_req.addr[PAGE_SHIFT-1:0]) ||
                            (size_rnd > {1'b0, r_req.addr})) begin
                            n_status = ST_INVALID;
                            n_state  = S_FIN;
                        end else begin
                            n_qb    = r_req.addr - size_rnd[31:0];
                            n_qt    = r_req.addr;
                            n_state = S_STK;
                        end
                    end
                    K_HEAP: begin
                        n_max   = 32'(PAGE_BYTES);
                        n_state = S_MAX;
                    end
                    K_BRK: begin
                        if (!r_heap_valid) begin
                            n_status = ST_NO_HEAP;
                            n_state  = S_FIN;
                        end else if (r_req.addr == 32'd0) begin
                            n_value = r_heap_base;
                            n_state = S_FIN;
                        end else if (r_req.addr < r_heap_base) begin
                            n_value = r_heap_base;
                            n_state = S_FIN;
                        end else begin
                            n_qb    = r_heap_base;
                            n_qt    = r_req.addr;
                            n_state = S_STK;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            // highest region top, one entry per cycle
            S_MAX: begin
                if (r_idx == r_count) begin
                    n_state = S_HEAP;
                end else begin
                    if (rd_data.top > r_max) begin
                        n_max = rd_data.top;
                    end
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_HEAP: begin
                if (r_stack_valid && (heap_rnd > {1'b0, r_stack_base})) begin
                    n_status = ST_MEETS;
                    n_state  = S_FIN;
                end else if (heap_rnd[32]) begin
                    n_status = ST_INVALID;
                    n_state  = S_FIN;
                end else begin
                    n_qb    = heap_rnd[31:0];
                    n_qt    = heap_rnd[31:0];
                    n_idx   = '0;
                    n_state = S_STK;
                end
            end
            // stack compare, table read of entry zero in flight
            S_STK: begin
                n_idx = '0;
                if (r_stack_valid && ov_hit) begin
                    n_status = ST_INVALID;
                    n_value  = '0;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_TBL;
                end
            end
            // table walk, commit when no entry overlaps
            S_TBL: begin
                if (r_idx == r_count) begin
                    n_state = S_FIN;
                    unique case (r_req.kind)
                        K_REGION: begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                        K_STACK: begin
                            n_stack_base  = r_qb;
                            n_stack_top   = r_qt;
                            n_stack_valid = 1'b1;
                        end
                        K_HEAP: begin
                            n_heap_base  = r_qb;
                            n_heap_valid = 1'b1;
                        end
                        K_BRK: begin
                            n_value = r_qt;
                        end
                        default: begin
                            n_value = '0;
                        end
                    endcase
                end else if (ov_hit) begin
                    n_status = ST_INVALID;
                    n_value  = '0;
                    n_state  = S_FIN;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            // hand the result to the output register once it is free
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = '{status: r_status, value: r_value};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_stack_valid <= 1'b0;
            r_heap_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_stack_valid <= n_stack_valid;
            r_heap_valid  <= n_heap_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_idx        <= n_idx;
        r_qb         <= n_qb;
        r_qt         <= n_qt;
        r_max        <= n_max;
        r_stack_base <= n_stack_base;
        r_stack_top  <= n_stack_top;
        r_heap_base  <= n_heap_base;
        r_status     <= n_status;
        r_value      <= n_value;
        r_out        <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // region count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REGIONS))
        else $error("region count past table depth");

    // a table write only lands in a free slot
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_count < CNT_W'(MAX_REGIONS)))
        else $error("table write with full table");

    // an accepted request always starts setup next
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_PREP))
        else $error("accepted request did not start");

    // scan index never runs past the stored regions
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_TBL) || (r_state == S_MAX)) |-> (r_idx <= r_count))
        else $error("scan index past region count");

    // leaving the finish state always loads a result beat
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (n_state == S_IDLE)) |=> o_out_valid)
        else $error("finished request lost its result");

endmodule

### sim/tb_region_map_overlap_checker.sv
// testbench for the region map overlap checker: directed and random requests against a predictor
module tb_region_map_overlap_checker;
    import rmoc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned TAIL_CYCLES  = 60;
    localparam int unsigned HOLD_AT      = 400;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_AT     = 700;
    localparam bit [63:0]   ADDR_TOP     = 64'hFFFF_FFFF;
    localparam bit [31:0]   PAGE_MASK    = PAGE_BYTES - 1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_data;

    region_map_overlap_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the region table, stack and heap
    bit [31:0]   tbl_base   [MAX_REGIONS];
    bit [31:0]   tbl_top    [MAX_REGIONS];
    bit [3:0]    tbl_rights [MAX_REGIONS];
    int unsigned tbl_count;
    bit [31:0]   stk_base, stk_top;
    bit          stk_valid;
    bit [31:0]   heap_lo, heap_brk;
    bit          heap_valid;

    // stimulus and scoreboard bookkeeping
    t_req        requests_pending[$];
    t_rsp        answers_due[$];
    bit [31:0]   tried_bases[$];
    int unsigned directed_count;
    int unsigned req_total;
    int unsigned req_offered;
    int unsigned req_taken;
    int unsigned rsp_seen;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;

    function automatic bit [63:0] page_ceil(input bit [63:0] v);
        return ((v + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    // [b1,t1) meets [b2,t2) unless wholly left or wholly right of it
    function automatic bit spans_meet(input bit [31:0] b1, t1, b2, t2);
        return !(((b1 < b2) && (t1 <= b2)) || ((b1 >= t2) && (t1 >= t2)));
    endfunction

    function automatic bit hits_map(input bit [31:0] b, input bit [31:0] t);
        if (stk_valid && spans_meet(b, t, stk_base, stk_top)) return 1'b1;
        for (int i = 0; i < tbl_count; i++)
            if (spans_meet(b, t, tbl_base[i], tbl_top[i])) return 1'b1;
        return 1'b0;
    endfunction

    // apply one request to the shadow map and return its answer
    function automatic t_rsp apply_map_request(input t_req r);
        t_rsp      res;
        bit [63:0] lo, hi, sz;
        res = '0;
        case (r.kind)
            K_REGION: begin
                lo = {32'b0, r.addr & ~PAGE_MASK};
                hi = lo + page_ceil({32'b0, r.length});
                if (tbl_count >= MAX_REGIONS) begin
                    res.status = ST_FULL;
                end else if (hi > ADDR_TOP || hits_map(lo[31:0], hi[31:0])) begin
                    res.status = ST_INVALID;
                end else begin
                    tbl_base[tbl_count]   = lo[31:0];
                    tbl_top[tbl_count]    = hi[31:0];
                    tbl_rights[tbl_count] = r.access_rights;
                    tbl_count++;
                end
            end
            K_STACK: begin
                sz = page_ceil({32'b0, r.length});
                if ((r.addr & PAGE_MASK) != 0 || sz > {32'b0, r.addr}) begin
                    res.status = ST_INVALID;
                end else begin
                    lo = {32'b0, r.addr} - sz;
                    if (hits_map(lo[31:0], r.addr)) begin
                        res.status = ST_INVALID;
                    end else begin
                        stk_base  = lo[31:0];
                        stk_top   = r.addr;
                        stk_valid = 1'b1;
                    end
                end
            end
            K_HEAP: begin
                // heap starts above the highest region top, one page at least
                lo = 64'(PAGE_BYTES);
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_top[i] > lo) lo = {32'b0, tbl_top[i]};
                lo = page_ceil(lo);
                if (stk_valid && lo > {32'b0, stk_base}) begin
                    res.status = ST_MEETS;
                end else if (lo > ADDR_TOP || hits_map(lo[31:0], lo[31:0])) begin
                    res.status = ST_INVALID;
                end else begin
                    heap_lo    = lo[31:0];
                    heap_brk   = lo[31:0];
                    heap_valid = 1'b1;
                end
            end
            K_BRK: begin
                if (!heap_valid) begin
                    res.status = ST_NO_HEAP;
                end else if (r.addr == 0) begin
                    res.value = heap_lo;
                end else if (r.addr < heap_lo) begin
                    heap_brk  = heap_lo;
                    res.value = heap_lo;
                end else if (hits_map(heap_lo, r.addr)) begin
                    res.status = ST_INVALID;
                end else begin
                    heap_brk  = r.addr;
                    res.value = r.addr;
                end
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(input logic [1:0] kind, input logic [31:0] addr,
                                 input logic [31:0] len, input logic [3:0] rights);
        t_req r;
        r.kind          = kind;
        r.addr          = addr;
        r.length        = len;
        r.access_rights = rights;
        requests_pending.push_back(r);
    endtask

    // mostly low-memory regions and high stacks so heap and break stay reachable
    function automatic t_req random_request();
        t_req        r;
        int unsigned pick, sel;
        r.access_rights = 4'($urandom);
        r.length        = $urandom_range(0, 8 * PAGE_BYTES);
        r.addr          = $urandom;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        if (pick < 15) begin
            r.kind = K_REGION;
            if (sel < 2) begin
                // fresh region, usually clear of the others
                r.addr = $urandom_range(32'h0001_0000, 32'h3FFF_FFFF);
                tried_bases.push_back(r.addr);
            end else if (sel < 7 && tried_bases.size() > 0) begin
                // within a page of an earlier base, mostly an overlap
                r.addr = tried_bases[$urandom_range(0, tried_bases.size() - 1)]
                         + $urandom_range(0, 2 * PAGE_BYTES) - PAGE_BYTES;
            end else begin
                // high base with a huge size always runs off the top
                r.addr   = $urandom | 32'h8000_0000;
                r.length = $urandom | 32'h8000_0000;
            end
        end else if (pick < 30) begin
            r.kind   = K_STACK;
            r.addr   = $urandom_range(32'h000C_0000, 32'h000F_FFFF) << PAGE_SHIFT;
            r.length = $urandom_range(0, 16 * PAGE_BYTES);
            if (sel == 7) begin
                // top off the page grid
                r.addr = r.addr | $urandom_range(1, PAGE_BYTES - 1);
            end else if (sel == 8) begin
                // size larger than the top
                r.addr   = $urandom_range(0, 15) << PAGE_SHIFT;
                r.length = r.addr + $urandom_range(1, 4 * PAGE_BYTES);
            end else if (sel == 9) begin
                r.addr   = $urandom;
                r.length = $urandom;
            end
        end else if (pick < 40) begin
            r.kind   = K_HEAP;
            r.length = $urandom;
        end else begin
            r.kind   = K_BRK;
            r.length = $urandom;
            if (sel < 2)
                r.addr = '0;
            else if (sel < 4)
                r.addr = $urandom_range(1, PAGE_BYTES - 1);
            else if (sel < 8)
                r.addr = $urandom_range(0, 32'h4800_0000);
        end
        return r;
    endfunction

    // idle length: mostly short, a few long, none inside some windows
    function automatic int unsigned pick_gap(input int unsigned n);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ((n / 100) % 4 == 1) return 0;
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // request driver: next beat only after the previous one is taken
    always @(negedge i_clk) begin
        logic nv;
        t_req nd;
        bit   draining;
        nv = i_in_valid;
        nd = i_in_data;
        if (i_rst_n) begin
            if (i_in_valid && req_taken == req_offered) nv = 1'b0;
            draining = (req_offered == directed_count || req_offered == DRAIN_AT)
                       && answers_due.size() != 0;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!draining && requests_pending.size() != 0) begin
                    nd = requests_pending.pop_front();
                    nv = 1'b1;
                    req_offered++;
                    send_gap = pick_gap(req_offered);
                end
            end
        end
        i_in_valid <= nv;
        i_in_data  <= nd;
    end

    // result ready: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        logic nr;
        nr = 1'b0;
        if (i_rst_n) begin
            if (!hold_done && rsp_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (stall_left > 0) begin
                stall_left--;
            end else begin
                nr = 1'b1;
                stall_left = pick_gap(rsp_seen + 200);
            end
        end
        i_out_ready <= nr;
    end

    // monitor: check result beats, predict on accepted request beats
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                if (o_out_valid && i_out_ready) begin
                    rsp_seen++;
                    if (answers_due.size() == 0) begin
                        $error("result beat with nothing expected: status %0d value %h",
                               o_out_data.status, o_out_data.value);
                        fail_count++;
                    end else begin
                        want = answers_due.pop_front();
                        if (o_out_data.status !== want.status) begin
                            $error("status: expected %0d, got %0d", want.status,
                                   o_out_data.status);
                            fail_count++;
                        end
                        if (o_out_data.value !== want.value) begin
                            $error("value: expected %h, got %h", want.value,
                                   o_out_data.value);
                            fail_count++;
                        end
                    end
                end
                if (i_in_valid && o_in_ready) begin
                    answers_due.push_back(apply_map_request(i_in_data));
                    req_taken++;
                end
            end
        end
    end

    initial begin
        int unsigned n;
        // break before any heap, then heap with an empty map
        queue_request(K_BRK,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        queue_request(K_HEAP,   32'h0000_0000, 32'h0000_0000, 4'h0);
        queue_request(K_BRK,    32'h0000_0000, 32'h0000_0000, 4'h0);
        queue_request(K_BRK,    32'h0000_0005, 32'h0000_0000, 4'h0);
        queue_request(K_BRK,    32'h0000_3000, 32'h0000_0000, 4'h0);
        // region rounding, zero-length overlap, running off the top
        queue_request(K_REGION, 32'h0000_1234, 32'h0000_0001, 4'hF);
        queue_request(K_REGION, 32'h0000_1800, 32'h0000_0000, 4'h0);
        queue_request(K_REGION, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0);
        queue_request(K_REGION, 32'h8000_0000, 32'h8000_0000, 4'hA);
        // stack misaligned, too large, then a low stack
        queue_request(K_STACK,  32'h1000_0001, 32'h0000_1000, 4'h0);
        queue_request(K_STACK,  32'h0000_1000, 32'h0000_2000, 4'h0);
        queue_request(K_STACK,  32'hFFFF_F000, 32'hFFFF_FFFF, 4'h0);
        queue_request(K_STACK,  32'h0000_4000, 32'h0000_1000, 4'h0);
        queue_request(K_HEAP,   32'h0000_0000, 32'h0000_0000, 4'h0);
        queue_request(K_BRK,    32'h0000_3800, 32'h0000_0000, 4'h0);
        queue_request(K_REGION, 32'h0000_2000, 32'h0000_2000, 4'h0);
        queue_request(K_REGION, 32'h0000_4000, 32'h0000_1000, 4'h5);
        // heap above the stack base, stack overlap, stack moved high
        queue_request(K_HEAP,   32'h0000_0000, 32'h0000_0000, 4'h0);
        queue_request(K_STACK,  32'h0000_4000, 32'h0000_0000, 4'h0);
        queue_request(K_STACK,  32'hFFFF_F000, 32'h0001_0000, 4'h0);
        queue_request(K_HEAP,   32'h0000_0000, 32'h0000_0000, 4'h0);
        queue_request(K_BRK,    32'hFFFF_FFFF, 32'h0000_0000, 4'h0);
        queue_request(K_BRK,    32'h0001_0000, 32'h0000_0000, 4'h0);
        // empty stack at zero, then heap meets it
        queue_request(K_STACK,  32'h0000_0000, 32'h0000_0000, 4'h0);
        queue_request(K_HEAP,   32'h0000_0000, 32'h0000_0000, 4'h0);
        queue_request(K_REGION, 32'hFFFF_F000, 32'h0000_0FFF, 4'h3);
        directed_count = requests_pending.size();
        for (n = 0; n < RANDOM_ITEMS; n++)
            requests_pending.push_back(random_request());
        req_total = requests_pending.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request taken and every answer back, then a short tail
        while (req_taken != req_total || answers_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
design/rmoc_pkg.sv
design/rmoc_region_table.sv
design/rmoc_overlap_unit.sv
design/region_map_overlap_checker.sv
sim/tb_region_map_overlap_checker.sv
